FILE: hw/rtl/mka_pkg.sv
package mka_pkg;

  localparam int unsigned PT_W  = 10;
  localparam int unsigned SLT_W = 4;
  localparam int unsigned NB_W  = 10;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned MAX_K_DEF      = 16;

  localparam int unsigned NP_W    = 11;
  localparam int unsigned KU_W    = 5;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [NP_W-1:0] NUM_POINTS_RST = 11'd1024;
  localparam logic [KU_W-1:0] K_USED_RST     = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_K_USED     = 1'b1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic             func;
    logic [PT_W-1:0]  point;
    logic [SLT_W-1:0] slot;
    logic [NB_W-1:0]  neighbor;
  } in_t;

  typedef struct packed {
    logic [NB_W-1:0] mutual_neighbor;
    logic            found;
    logic            last;
  } out_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LD_RD  = 8'b0000_0010,
    ST_LD_WR  = 8'b0000_0100,
    ST_Q_RD   = 8'b0000_1000,
    ST_Q_ROW  = 8'b0001_0000,
    ST_Q_SCAN = 8'b0010_0000,
    ST_Q_CHK  = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic capture;
    logic ram_re;
    logic sel_cand;
    logic ram_we;
    logic own_ld;
    logic s_inc;
    logic push_hit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic ld_ok;
    logic p_ok;
    logic scan_done;
    logic skip;
    logic hit;
    logic pend_vld;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/mka_ram.sv
module mka_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/mka_ctrl.sv
module mka_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mka_pkg::sts_t sts_i,
  output mka_pkg::cmd_t cmd_o
);

  mka_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mka_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mka_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = sts_i.is_query ? mka_pkg::ST_Q_RD : mka_pkg::ST_LD_RD;
        end
      end
      mka_pkg::ST_LD_RD: begin
        // Loads merge one slot into the stored row, so the row is read first.
        cmd_o.ram_re = 1'b1;
        state_d = sts_i.ld_ok ? mka_pkg::ST_LD_WR : mka_pkg::ST_IDLE;
      end
      mka_pkg::ST_LD_WR: begin
        cmd_o.ram_we = 1'b1;
        state_d = mka_pkg::ST_IDLE;
      end
      mka_pkg::ST_Q_RD: begin
        cmd_o.ram_re = 1'b1;
        state_d = sts_i.p_ok ? mka_pkg::ST_Q_ROW : mka_pkg::ST_FINISH;
      end
      mka_pkg::ST_Q_ROW: begin
        cmd_o.own_ld = 1'b1;
        state_d = mka_pkg::ST_Q_SCAN;
      end
      mka_pkg::ST_Q_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = mka_pkg::ST_FINISH;
        end else if (sts_i.skip) begin
          cmd_o.s_inc = 1'b1;
        end else begin
          cmd_o.ram_re   = 1'b1;
          cmd_o.sel_cand = 1'b1;
          state_d = mka_pkg::ST_Q_CHK;
        end
      end
      mka_pkg::ST_Q_CHK: begin
        // A hit displaces the held result, which needs a free output register.
        if (!sts_i.hit) begin
          cmd_o.s_inc = 1'b1;
          state_d = mka_pkg::ST_Q_SCAN;
        end else if (!sts_i.pend_vld || sts_i.out_free) begin
          cmd_o.push_hit = 1'b1;
          cmd_o.s_inc    = 1'b1;
          state_d = mka_pkg::ST_Q_SCAN;
        end
      end
      mka_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = mka_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mka_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/mka_dp.sv
module mka_dp #(
  parameter int unsigned MAX_POINTS = mka_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_K      = mka_pkg::MAX_K_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mka_pkg::in_t                    in_data_i,
  input  logic                            cfg_we_i,
  input  logic [mka_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mka_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  mka_pkg::cmd_t                   cmd_i,
  output mka_pkg::sts_t                   sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output mka_pkg::out_t                   out_data_o
);

  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned KCW = $clog2(MAX_K + 1);
  localparam int unsigned RW  = MAX_K * mka_pkg::NB_W;

  typedef logic [MAX_K-1:0][mka_pkg::NB_W-1:0] row_t;

  mka_pkg::in_t                item_q;
  row_t                        own_row_q;
  row_t                        rd_row;
  row_t                        wr_row;
  logic [KCW-1:0]              s_q;
  logic [mka_pkg::NB_W-1:0]    pend_q;
  logic                        pend_vld_q;
  mka_pkg::out_t               out_q;
  logic                        out_vld_q;
  logic [mka_pkg::NP_W-1:0]    num_q;
  logic [mka_pkg::KU_W-1:0]    kused_q;

  logic [16:0]                 n_eff;
  logic [16:0]                 np_ext;
  logic [6:0]                  k_ext;
  logic [KCW-1:0]              k_eff;
  logic [16:0]                 pt_ext;
  logic [16:0]                 cand_ext;
  logic [6:0]                  slot_ext;
  logic [KW-1:0]               slot_idx;
  logic [KW-1:0]               s_idx;
  logic [mka_pkg::NB_W-1:0]    cand;
  logic                        rep;
  logic                        hit;
  logic                        out_free;
  logic [AW-1:0]               ram_addr;
  logic [RW-1:0]               ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q   <= mka_pkg::NUM_POINTS_RST;
      kused_q <= mka_pkg::K_USED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mka_pkg::CFG_NUM_POINTS: num_q   <= cfg_wdata_i;
        mka_pkg::CFG_K_USED:     kused_q <= cfg_wdata_i[mka_pkg::KU_W-1:0];
        default: ;
      endcase
    end
  end

  assign np_ext = {6'd0, num_q};
  assign n_eff  = (np_ext > 17'(MAX_POINTS)) ? 17'(MAX_POINTS) : np_ext;
  assign k_ext  = {2'd0, kused_q};
  assign k_eff  = (k_ext > 7'(MAX_K)) ? KCW'(MAX_K) : KCW'(k_ext);

  assign pt_ext   = {7'd0, item_q.point};
  assign slot_ext = {3'd0, item_q.slot};
  assign slot_idx = slot_ext[KW-1:0];
  assign s_idx    = s_q[KW-1:0];
  assign cand     = own_row_q[s_idx];
  assign cand_ext = {7'd0, cand};

  assign rd_row   = ram_rdata;
  assign ram_addr = cmd_i.sel_cand ? cand_ext[AW-1:0] : pt_ext[AW-1:0];

  always_comb begin
    wr_row           = rd_row;
    wr_row[slot_idx] = item_q.neighbor;
  end

  // A candidate counts only at its first place in the row.
  always_comb begin
    rep = 1'b0;
    for (int t = 0; t < MAX_K; t++) begin
      if ((KCW'(t) < s_q) && (own_row_q[t] == cand)) begin
        rep = 1'b1;
      end
    end
  end

  // The candidate's row is searched for the queried point in one step.
  always_comb begin
    hit = 1'b0;
    for (int t = 0; t < MAX_K; t++) begin
      if ((KCW'(t) < k_eff) && (rd_row[t] == item_q.point)) begin
        hit = 1'b1;
      end
    end
  end

  mka_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .re_i    (cmd_i.ram_re),
    .addr_i  (ram_addr),
    .wdata_i (wr_row),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.own_ld) begin
      own_row_q <= rd_row;
    end
    if (cmd_i.push_hit) begin
      pend_q <= cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
    end else if (cmd_i.own_ld) begin
      s_q <= '0;
    end else if (cmd_i.s_inc) begin
      s_q <= s_q + KCW'(1);
    end
  end

  assign out_free = !out_vld_q || out_ready_i;

  // One found result is held back until it is known whether it is the last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.push_hit) begin
        pend_vld_q <= 1'b1;
        if (pend_vld_q) begin
          out_vld_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        pend_vld_q <= 1'b0;
        out_vld_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_hit && pend_vld_q) begin
      out_q.mutual_neighbor <= pend_q;
      out_q.found           <= 1'b1;
      out_q.last            <= 1'b0;
    end else if (cmd_i.finish) begin
      out_q.mutual_neighbor <= pend_vld_q ? pend_q : '0;
      out_q.found           <= pend_vld_q;
      out_q.last            <= 1'b1;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign sts_o.is_query  = (in_data_i.func == mka_pkg::FUNC_QUERY);
  assign sts_o.ld_ok     = (pt_ext < 17'(MAX_POINTS)) && (slot_ext < 7'(MAX_K));
  assign sts_o.p_ok      = (pt_ext < n_eff);
  assign sts_o.scan_done = (s_q >= k_eff);
  assign sts_o.skip      = (cand_ext >= n_eff) || (cand == item_q.point) || rep;
  assign sts_o.hit       = hit;
  assign sts_o.pend_vld  = pend_vld_q;
  assign sts_o.out_free  = out_free;

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push_hit && pend_vld_q) |-> out_free)
    else $error("result pushed over an undelivered beat");

  a_finish_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> out_free)
    else $error("final result pushed over an undelivered beat");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.found) |-> (out_q.last && (out_q.mutual_neighbor == '0)))
    else $error("empty answer is not a single cleared last beat");

  a_ram_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.ram_we && cmd_i.ram_re))
    else $error("table read and written in the same cycle");

  a_pend_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> !pend_vld_q)
    else $error("held result survives the end of a query");
`endif

endmodule

FILE: hw/rtl/mutual_knn_adjacency.sv
// Mutual kNN adjacency engine.
// Input channel (in_valid_i/in_ready_o, in_data_i): a beat with func = load
// writes one neighbor index into the table at (point, slot); it gives no
// result. A beat with func = query returns the mutual
// neighbors of point, in first-occurrence slot order, on the output channel
// (out_valid_o/out_ready_i, out_data_o), the last beat flagged by last. A
// query without a mutual neighbor returns one beat with found clear.
// A query reads its own row, then scans the used slots of that row; each
// candidate that passes the skip checks has its full row read from the
// single-port table memory, and that row is compared against the query
// point in one step.
// One item is in work at a time; the next is taken once the previous one has
// finished. Results leave through an output register, so a stalled receiver
// holds the engine only when a further result has to be pushed.
// The user must write num_points and k_used (cfg_we_i/cfg_idx_i/cfg_wdata_i)
// only while idle (the block does not enforce it); reset sets them to 1024
// and 16 and empties the output; table contents are undefined until loaded.
module mutual_knn_adjacency #(
  parameter int unsigned MAX_POINTS = mka_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_K      = mka_pkg::MAX_K_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mka_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mka_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [mka_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mka_pkg::CFG_W-1:0]     cfg_wdata_i
);

  mka_pkg::cmd_t cmd;
  mka_pkg::sts_t sts;

  mka_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mka_dp #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_K      (MAX_K)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int POOL_N = 5;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  mka_pkg::in_t                  in_data_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  mka_pkg::out_t                 out_data_o;
  logic                          cfg_we_i;
  logic [mka_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [mka_pkg::CFG_W-1:0]     cfg_wdata_i;

  mutual_knn_adjacency dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mirror of the neighbor table and of the two registers.
  logic [mka_pkg::NB_W-1:0] nb_model   [mka_pkg::MAX_POINTS_DEF][mka_pkg::MAX_K_DEF];
  bit                       nb_written [mka_pkg::MAX_POINTS_DEF][mka_pkg::MAX_K_DEF];
  logic [mka_pkg::NP_W-1:0] num_points_cfg = mka_pkg::NUM_POINTS_RST;
  logic [mka_pkg::KU_W-1:0] k_used_cfg     = mka_pkg::K_USED_RST;

  // Rows that are loaded in full at the start; 0 and 1023 toggle every bit.
  logic [mka_pkg::PT_W-1:0] pool_pts [POOL_N] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd1023};

  mka_pkg::out_t adj_expect_q [$];
  int            mismatch_cnt = 0;
  int            burst_left   = 0;
  bit            hold_req     = 1'b0;

  function automatic void predict_adjacency(input logic [mka_pkg::PT_W-1:0] p);
    int unsigned              n, k, s, t;
    logic [mka_pkg::NB_W-1:0] j;
    bit                       skip, mutual, have_pending;
    mka_pkg::out_t            pending;
    n = (num_points_cfg > mka_pkg::MAX_POINTS_DEF) ? mka_pkg::MAX_POINTS_DEF : num_points_cfg;
    k = (k_used_cfg > mka_pkg::MAX_K_DEF) ? mka_pkg::MAX_K_DEF : k_used_cfg;
    have_pending = 1'b0;
    pending = '0;
    if (p < n) begin
      for (s = 0; s < k; s++) begin
        j = nb_model[p][s];
        skip = (j >= n) || (j == p);
        for (t = 0; t < s; t++) begin
          if (nb_model[p][t] == j) skip = 1'b1;
        end
        if (!skip) begin
          mutual = 1'b0;
          for (t = 0; t < k; t++) begin
            if (nb_model[j][t] == p) mutual = 1'b1;
          end
          if (mutual) begin
            if (have_pending) adj_expect_q = {adj_expect_q, pending};
            pending.mutual_neighbor = j;
            pending.found = 1'b1;
            pending.last = 1'b0;
            have_pending = 1'b1;
          end
        end
      end
    end
    // The final beat carries last; an empty answer is a single beat.
    pending.last = 1'b1;
    adj_expect_q = {adj_expect_q, pending};
  endfunction

  function automatic bit row_full(input logic [mka_pkg::PT_W-1:0] r);
    for (int s = 0; s < mka_pkg::MAX_K_DEF; s++) begin
      if (!nb_written[r][s]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // A query may only touch rows that are loaded in every slot.
  function automatic bit query_is_safe(input logic [mka_pkg::PT_W-1:0] p);
    int unsigned              n, k;
    logic [mka_pkg::NB_W-1:0] j;
    n = (num_points_cfg > mka_pkg::MAX_POINTS_DEF) ? mka_pkg::MAX_POINTS_DEF : num_points_cfg;
    k = (k_used_cfg > mka_pkg::MAX_K_DEF) ? mka_pkg::MAX_K_DEF : k_used_cfg;
    if (p >= n) return 1'b1;
    if (!row_full(p)) return 1'b0;
    for (int s = 0; s < k; s++) begin
      j = nb_model[p][s];
      if (j < n && j != p && !row_full(j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit pick_query_point(output logic [mka_pkg::PT_W-1:0] p);
    for (int tries = 0; tries < 8; tries++) begin
      if ($urandom_range(0, 99) < 15) begin
        p = mka_pkg::PT_W'($urandom_range(0, mka_pkg::MAX_POINTS_DEF - 1));
      end else begin
        p = pool_pts[$urandom_range(0, POOL_N - 1)];
      end
      if (query_is_safe(p)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic mka_pkg::in_t make_query(input logic [mka_pkg::PT_W-1:0] p);
    mka_pkg::in_t it;
    it.func = mka_pkg::FUNC_QUERY;
    it.point = p;
    it.slot = mka_pkg::SLT_W'($urandom);
    it.neighbor = mka_pkg::NB_W'($urandom);
    return it;
  endfunction

  function automatic mka_pkg::in_t make_load(input logic [mka_pkg::PT_W-1:0] p,
                                             input logic [mka_pkg::SLT_W-1:0] s,
                                             input logic [mka_pkg::NB_W-1:0] nb);
    mka_pkg::in_t it;
    it.func = mka_pkg::FUNC_LOAD;
    it.point = p;
    it.slot = s;
    it.neighbor = nb;
    return it;
  endfunction

  task automatic send_item(input mka_pkg::in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.func == mka_pkg::FUNC_LOAD) begin
      nb_model[it.point][it.slot] = it.neighbor;
      nb_written[it.point][it.slot] = 1'b1;
    end else begin
      predict_adjacency(it.point);
    end
  endtask

  // Stop offering beats, let every result arrive, then let a load finish.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (adj_expect_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [mka_pkg::NP_W-1:0] np,
                            input logic [mka_pkg::KU_W-1:0] ku);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= mka_pkg::CFG_NUM_POINTS;
    cfg_wdata_i <= mka_pkg::CFG_W'(np);
    @(posedge clk_i);
    cfg_idx_i   <= mka_pkg::CFG_K_USED;
    cfg_wdata_i <= {6'($urandom), ku};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    num_points_cfg = np;
    k_used_cfg = ku;
  endtask

  task automatic send_random_load();
    logic [mka_pkg::PT_W-1:0] p;
    logic [mka_pkg::NB_W-1:0] nb;
    int                       r;
    if ($urandom_range(0, 99) < 85) p = pool_pts[$urandom_range(0, POOL_N - 1)];
    else p = mka_pkg::PT_W'($urandom_range(0, mka_pkg::MAX_POINTS_DEF - 1));
    r = $urandom_range(0, 99);
    if (r < 70) nb = pool_pts[$urandom_range(0, POOL_N - 1)];
    else if (r < 85) nb = p;
    else nb = mka_pkg::NB_W'($urandom_range(0, mka_pkg::MAX_POINTS_DEF - 1));
    send_item(make_load(p, mka_pkg::SLT_W'($urandom_range(0, mka_pkg::MAX_K_DEF - 1)), nb));
  endtask

  task automatic check_result(input mka_pkg::out_t got);
    mka_pkg::out_t want;
    if (adj_expect_q.size() == 0) begin
      $display("%0t: unexpected beat: expected none, actual nb=%0d found=%0b last=%0b",
               $time, got.mutual_neighbor, got.found, got.last);
      mismatch_cnt++;
      return;
    end
    want = adj_expect_q.pop_front();
    if (got.mutual_neighbor !== want.mutual_neighbor) begin
      $display("%0t: mutual_neighbor expected %0d actual %0d",
               $time, want.mutual_neighbor, got.mutual_neighbor);
      mismatch_cnt++;
    end
    if (got.found !== want.found) begin
      $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
      mismatch_cnt++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
      mismatch_cnt++;
    end
  endtask

  // Receiver: changes its stall pattern now and then, and holds off on request.
  initial begin : result_sink
    int hold_cnt, mode, mode_left, cyc;
    out_ready_i = 1'b0;
    hold_cnt = 0;
    mode = 0;
    mode_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) check_result(out_data_o);
      cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 250;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (cyc % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic test_table_fill();
    for (int i = 0; i < POOL_N; i++) begin
      for (int s = 0; s < mka_pkg::MAX_K_DEF; s++) begin
        send_item(make_load(pool_pts[i], mka_pkg::SLT_W'(s),
                            pool_pts[$urandom_range(0, POOL_N - 1)]));
      end
    end
  endtask

  task automatic test_default_queries();
    for (int i = 0; i < POOL_N; i++) send_item(make_query(pool_pts[i]));
  endtask

  task automatic test_register_extremes();
    set_config(11'd0, 5'd16);
    send_item(make_query(10'd0));
    send_item(make_query(10'd1023));
    // Values above the maximum act as the maximum.
    set_config(11'd2047, 5'd31);
    send_item(make_query(10'd1));
    send_item(make_query(10'd1023));
    set_config(11'd1024, 5'd0);
    send_item(make_query(10'd3));
    set_config(11'd1024, 5'd1);
    send_item(make_query(10'd0));
    send_item(make_query(10'd1));
    send_item(make_query(10'd2));
    set_config(11'd1, 5'd16);
    send_item(make_query(10'd0));
    send_item(make_query(10'd1023));
  endtask

  task automatic test_skip_cases();
    set_config(11'd1024, 5'd16);
    // Row 2 holds itself, a repeated entry and the highest point index.
    send_item(make_load(10'd2, 4'd0, 10'd2));
    send_item(make_load(10'd2, 4'd1, 10'd3));
    send_item(make_load(10'd2, 4'd2, 10'd3));
    send_item(make_load(10'd2, 4'd3, 10'd1023));
    send_item(make_load(10'd3, 4'd0, 10'd2));
    send_item(make_load(10'd1023, 4'd15, 10'd2));
    send_item(make_query(10'd2));
    set_config(11'd5, 5'd16);
    send_item(make_query(10'd2));
  endtask

  task automatic test_backpressure();
    set_config(11'd1024, 5'd16);
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_item(make_query(pool_pts[$urandom_range(0, POOL_N - 1)]));
    wait_idle();
    for (int i = 0; i < 2; i++) send_item(make_query(pool_pts[$urandom_range(0, POOL_N - 1)]));
  endtask

  task automatic test_random_mix();
    logic [mka_pkg::PT_W-1:0] p;
    logic [mka_pkg::NP_W-1:0] np;
    logic [mka_pkg::KU_W-1:0] ku;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin np = 11'd1024; ku = 5'd16; end
        1: begin np = 11'd6; ku = mka_pkg::KU_W'($urandom_range(1, 16)); end
        2: begin
          np = mka_pkg::NP_W'($urandom_range(0, 2047));
          ku = mka_pkg::KU_W'($urandom_range(0, 31));
        end
        3: begin np = 11'd2; ku = 5'd31; end
        default: begin np = 11'd1024; ku = mka_pkg::KU_W'($urandom_range(1, 16)); end
      endcase
      set_config(np, ku);
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(0, 99) < 60 && pick_query_point(p)) send_item(make_query(p));
        else send_random_load();
      end
    end
  endtask

  initial begin : main
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = mka_pkg::CFG_NUM_POINTS;
    cfg_wdata_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_fill();
    test_default_queries();
    test_register_extremes();
    test_skip_cases();
    test_backpressure();
    test_random_mix();
    wait_idle();
    if (mismatch_cnt == 0 && adj_expect_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mka_pkg.sv
hw/rtl/mka_ram.sv
hw/rtl/mka_ctrl.sv
hw/rtl/mka_dp.sv
hw/rtl/mutual_knn_adjacency.sv
tb/tb.sv
